// ===== rtl/core/sidd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sidd_pkg;

  localparam int unsigned BinW   = 32;
  localparam int unsigned Digits = 10;
  localparam int unsigned BcdW   = 4 * Digits;
  localparam int unsigned CntW   = $clog2(BinW);
  localparam int unsigned RemW   = $clog2(Digits + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic rem_one;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sidd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sidd_dp (
  input  wire logic                                clk_i,
  input  wire logic [sidd_pkg::BinW-1:0]           value_i,
  input  wire sidd_pkg::cmd_t                      cmd_i,
  output sidd_pkg::status_t                        status_o,
  output logic [3:0]                               digit_o
);

  logic [sidd_pkg::BinW-1:0] bin_q, bin_d;
  logic [sidd_pkg::BcdW-1:0] bcd_q, bcd_d;
  logic [sidd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [sidd_pkg::RemW-1:0] rem_q, rem_d;
  logic [sidd_pkg::BcdW-1:0] bcd_adj;
  logic [sidd_pkg::BinW-1:0] mag;

  // two's complement negate; the most negative value maps to 2^31 unchanged
  assign mag = value_i[sidd_pkg::BinW-1] ? (~value_i + sidd_pkg::BinW'(1)) : value_i;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sidd_pkg::Digits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      bin_d = mag;
      bcd_d = '0;
      cnt_d = '0;
      rem_d = sidd_pkg::RemW'(sidd_pkg::Digits);
    end else if (cmd_i.step) begin
      bcd_d = {bcd_adj[sidd_pkg::BcdW-2:0], bin_q[sidd_pkg::BinW-1]};
      bin_d = {bin_q[sidd_pkg::BinW-2:0], 1'b0};
      cnt_d = cnt_q + sidd_pkg::CntW'(1);
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_q[sidd_pkg::BcdW-5:0], 4'd0};
      rem_d = rem_q - sidd_pkg::RemW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
  end

  assign digit_o            = bcd_q[sidd_pkg::BcdW-1 -: 4];
  assign status_o.conv_done = (cnt_q == {sidd_pkg::CntW{1'b1}});
  assign status_o.top_zero  = (digit_o == 4'd0);
  assign status_o.rem_one   = (rem_q == sidd_pkg::RemW'(1));

endmodule
`default_nettype wire

// ===== rtl/core/sidd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sidd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire sidd_pkg::status_t   status_i,
  output sidd_pkg::cmd_t           cmd_o
);

  sidd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sidd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sidd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sidd_pkg::ST_CONV;
      end
      sidd_pkg::ST_CONV: begin
        if (status_i.conv_done) state_d = sidd_pkg::ST_SKIP;
      end
      sidd_pkg::ST_SKIP: begin
        if (!status_i.top_zero || status_i.rem_one) state_d = sidd_pkg::ST_EMIT;
      end
      sidd_pkg::ST_EMIT: begin
        if (!out_stall_i && status_i.rem_one) state_d = sidd_pkg::ST_IDLE;
      end
      default: state_d = sidd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      sidd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      sidd_pkg::ST_CONV: begin
        cmd_o.step = 1'b1;
      end
      sidd_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        cmd_o.shift = status_i.top_zero && !status_i.rem_one;
      end
      sidd_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.shift = !out_stall_i && !status_i.rem_one;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_digits_top.sv =====
// a load, then a shift-add-3 step per bit of the 32-bit magnitude, then one shift per
// leading zero dropped plus a step to leave the skip, then the digit items (1 to 10),
// one per handshake while out_stall_i is low; the iterative double-dabble loop takes a
// new input item only after the last digit is out; digits plus dropped zeros always make 10
// reset: asynchronous active-low rst_ni returns the controller to idle, no item pending
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_digits_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic signed [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       digit_o,
  output logic             last_o
);

  sidd_pkg::cmd_t    cmd;
  sidd_pkg::status_t status;

  sidd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sidd_dp u_dp (
    .clk_i    (clk_i),
    .value_i  (value_i),
    .cmd_i    (cmd),
    .status_o (status),
    .digit_o  (digit_o)
  );

  assign last_o = status.rem_one;

endmodule
`default_nettype wire
